FILE: hw/rtl/csp_pkg.sv
package csp_pkg;

  // Field and register widths
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned ANG_W    = 16;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned RAD_W    = 10;
  localparam int unsigned PIX_W    = 12;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Screen geometry
  localparam int unsigned WINDOW_WIDTH  = 1280;
  localparam int unsigned WINDOW_HEIGHT = 720;
  localparam int unsigned MAX_SEATS_DEF = 256;

  // Reset values of the configuration registers
  localparam logic [ANG_W-1:0] START_ANGLE_RST  = 16'd16384;
  localparam logic [CNT_W-1:0] SEAT_COUNT_RST   = 9'd1;
  localparam logic [RAD_W-1:0] TABLE_RADIUS_RST = 10'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE  = 2'd0,
    REG_SEAT_COUNT   = 2'd1,
    REG_TABLE_RADIUS = 2'd2
  } cfg_reg_t;

  // Divider: one quotient bit per cell, dividend is seat_index * 2^16
  localparam int unsigned DIV_STEPS = IDX_W + ANG_W;

  // Rotation: angles in 2^32 units per turn, vector in Q30
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XY_W = 33;
  localparam int unsigned Z_W  = 34;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // Sine/cosine in Q16, range -65536..65536
  localparam int unsigned TRIG_W = 18;
  localparam int unsigned PROD_W = RAD_W + 1 + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // Input register to output strobe, in cycles
  localparam int unsigned LATENCY = DIV_STEPS + CORDIC_STEPS + 4;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [ANG_W-1:0] quot;
  } div_stage_t;

  typedef struct packed {
    logic valid;
    logic flip;
  } cordic_ctl_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  // atan(2^-step) in 2^32 units per turn
  function automatic logic signed [Z_W-1:0] arc_of(input int unsigned step);
    logic [31:0] a;
    case (step)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return signed'(Z_W'(a));
  endfunction

endpackage

FILE: hw/rtl/csp_div_cell.sv
module csp_div_cell #(
  parameter int unsigned STEP  = 0,
  parameter int unsigned DIV_W = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DIV_W-1:0]    divisor,
  input  csp_pkg::div_stage_t stage_in,
  input  logic [DIV_W-1:0]    rem_in,
  output csp_pkg::div_stage_t stage_out,
  output logic [DIV_W-1:0]    rem_out
);
  import csp_pkg::*;

  logic [IDX_W-1:0] idx_shift;
  logic             dbit;
  logic [DIV_W:0]   trial;
  logic             ge;

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [ANG_W-1:0] quot_r, quot_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;

  // Bring down the next dividend bit; past the index bits they are zero
  assign idx_shift = stage_in.idx << STEP;
  assign dbit      = idx_shift[IDX_W-1];
  assign trial     = {rem_in, dbit};
  assign ge        = (trial >= {1'b0, divisor});

  always_comb begin
    valid_nxt = stage_in.valid;
    idx_nxt   = stage_in.idx;
    quot_nxt  = {stage_in.quot[ANG_W-2:0], ge};
    if (ge) begin
      rem_nxt = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign stage_out = '{valid: valid_r, idx: idx_r, quot: quot_r};
  assign rem_out   = rem_r;

endmodule

FILE: hw/rtl/csp_cordic_cell.sv
module csp_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csp_pkg::cordic_ctl_t ctl_in,
  input  csp_pkg::cordic_vec_t vec_in,
  output csp_pkg::cordic_ctl_t ctl_out,
  output csp_pkg::cordic_vec_t vec_out
);
  import csp_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  arc;

  cordic_ctl_t ctl_r, ctl_nxt;
  cordic_vec_t vec_r, vec_nxt;

  assign dx  = vec_in.y >>> STEP;
  assign dy  = vec_in.x >>> STEP;
  assign arc = arc_of(STEP);

  // Rotate toward zero residual angle
  always_comb begin
    ctl_nxt = ctl_in;
    if (!vec_in.z[Z_W-1]) begin
      vec_nxt.x = vec_in.x - dx;
      vec_nxt.y = vec_in.y + dy;
      vec_nxt.z = vec_in.z - arc;
    end else begin
      vec_nxt.x = vec_in.x + dx;
      vec_nxt.y = vec_in.y - dy;
      vec_nxt.z = vec_in.z + arc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign ctl_out = ctl_r;
  assign vec_out = vec_r;

endmodule

FILE: hw/rtl/circle_seat_position.sv
// Seat placement on a circle. Each transaction takes a seat index and then
// strobes out_valid for one cycle with the seat's screen coordinates on
// out_pixel_x / out_pixel_y. A new index may be started in every cycle; busy
// is high only during reset and for the cycle after it. The result is shown
// for exactly one cycle and cannot be held off, so the receiver must take it
// when out_valid is high. Each index runs through the 24-cell divider
// (index * 65536 / seat_count, one quotient bit per cell), an angle register,
// the 24-cell rotation chain and registers that round, scale by the radius
// and offset to the window center. The user must write configuration through
// cfg_we / cfg_index / cfg_wdata only while no transaction is in flight; the
// block does not enforce this. Index 0 is the start angle, 1 the seat count
// (0 acts as 1, values above MAX_SEATS saturate), 2 the radius, 3 is ignored.
// Coordinates truncate toward zero and saturate to 0..4095.
module circle_seat_position #(
  parameter int unsigned MAX_SEATS = csp_pkg::MAX_SEATS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [csp_pkg::IDX_W-1:0]     in_seat_index,
  output logic                          out_valid,
  output logic [csp_pkg::PIX_W-1:0]     out_pixel_x,
  output logic [csp_pkg::PIX_W-1:0]     out_pixel_y,
  input  logic                          cfg_we,
  input  logic [csp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csp_pkg::CFG_W-1:0]     cfg_wdata
);
  import csp_pkg::*;

  localparam int unsigned DIV_W  = $clog2(MAX_SEATS + 1);
  localparam int unsigned WIDE_W = DIV_W + CNT_W;

  localparam logic signed [Z_W-1:0]   QUARTER_TURN = Z_W'(64'sd1073741824);
  localparam logic signed [Z_W-1:0]   HALF_TURN    = Z_W'(64'sd2147483648);
  localparam logic signed [XY_W-1:0]  ROUND_BIAS   = XY_W'(15'sd8192);
  localparam logic signed [XY_W-1:0]  Q16_ONE      = XY_W'(20'sd65536);
  localparam logic signed [XY_W-1:0]  Q16_NEG_ONE  = -Q16_ONE;
  localparam logic signed [SUM_W-1:0] CENTER_X     =
    SUM_W'((WINDOW_WIDTH / 2) * 65536);
  localparam logic signed [SUM_W-1:0] CENTER_Y     =
    SUM_W'((WINDOW_HEIGHT / 2) * 65536);
  localparam logic [SUM_W-17:0]       PIX_LIMIT    = (SUM_W-16)'(4095);

  // Configuration registers
  logic [ANG_W-1:0] start_angle_r;
  logic [CNT_W-1:0] seat_count_r;
  logic [RAD_W-1:0] table_radius_r;

  logic              busy_r;
  logic [WIDE_W-1:0] count_wide;
  logic [DIV_W-1:0]  divisor;

  div_stage_t       div_chain [DIV_STEPS+1];
  logic [DIV_W-1:0] rem_chain [DIV_STEPS+1];

  cordic_ctl_t cor_ctl [CORDIC_STEPS+1];
  cordic_vec_t cor_vec [CORDIC_STEPS+1];

  // Angle stage
  logic [ANG_W-1:0]      angle;
  logic signed [31:0]    z_raw;
  logic signed [Z_W-1:0] z_wide;
  cordic_ctl_t           prep_ctl_r, prep_ctl_nxt;
  cordic_vec_t           prep_vec_r, prep_vec_nxt;

  // Round stage
  logic signed [XY_W-1:0]   x_flip, y_flip, x_sh, y_sh;
  logic                     rnd_valid_r;
  logic signed [TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;

  // Scale stage
  logic                     mul_valid_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;

  // Offset and saturate stage
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                    out_valid_r;
  logic [PIX_W-1:0]        pixel_x_r, pixel_x_nxt, pixel_y_r, pixel_y_nxt;

  // Clamp to ±1.0 in Q16
  function automatic logic signed [TRIG_W-1:0] clamp_q16(input logic signed [XY_W-1:0] v);
    if (v > Q16_ONE) begin
      return TRIG_W'(Q16_ONE);
    end else if (v < Q16_NEG_ONE) begin
      return TRIG_W'(Q16_NEG_ONE);
    end
    return TRIG_W'(v);
  endfunction

  // Drop the fraction; negative sums land at zero, large ones at the edge
  function automatic logic [PIX_W-1:0] to_pixel(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-17:0] whole;
    whole = s[SUM_W-1:16];
    if (s[SUM_W-1]) begin
      return '0;
    end else if (whole > PIX_LIMIT) begin
      return '1;
    end
    return whole[PIX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r  <= START_ANGLE_RST;
      seat_count_r   <= SEAT_COUNT_RST;
      table_radius_r <= TABLE_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_ANGLE:  start_angle_r  <= cfg_wdata[ANG_W-1:0];
        REG_SEAT_COUNT:   seat_count_r   <= cfg_wdata[CNT_W-1:0];
        REG_TABLE_RADIUS: table_radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold busy through reset and the cycle after it; the pipeline never stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r | ~rst_n;

  // Divisor: zero seats acts as one, too many saturate
  assign count_wide = WIDE_W'(seat_count_r);
  always_comb begin
    if (count_wide == '0) begin
      divisor = DIV_W'(1);
    end else if (count_wide > WIDE_W'(MAX_SEATS)) begin
      divisor = DIV_W'(MAX_SEATS);
    end else begin
      divisor = DIV_W'(count_wide);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider chain: index * 65536 / count, low 16 quotient bits kept
  // ---------------------------------------------------------------------------
  assign div_chain[0] = '{valid: start & ~busy, idx: in_seat_index, quot: '0};
  assign rem_chain[0] = '0;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    csp_div_cell #(
      .STEP  (g),
      .DIV_W (DIV_W)
    ) u_div_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (divisor),
      .stage_in  (div_chain[g]),
      .rem_in    (rem_chain[g]),
      .stage_out (div_chain[g+1]),
      .rem_out   (rem_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Angle stage: subtract offset, map to signed turn, fold into ±quarter turn
  // ---------------------------------------------------------------------------
  assign angle  = start_angle_r - div_chain[DIV_STEPS].quot;
  assign z_raw  = {angle, 16'h0000};
  assign z_wide = Z_W'(z_raw);

  always_comb begin
    prep_ctl_nxt.valid = div_chain[DIV_STEPS].valid;
    prep_ctl_nxt.flip  = 1'b0;
    prep_vec_nxt.x     = CORDIC_GAIN;
    prep_vec_nxt.y     = '0;
    prep_vec_nxt.z     = z_wide;
    if (z_wide > QUARTER_TURN) begin
      prep_vec_nxt.z    = z_wide - HALF_TURN;
      prep_ctl_nxt.flip = 1'b1;
    end else if (z_wide < -QUARTER_TURN) begin
      prep_vec_nxt.z    = z_wide + HALF_TURN;
      prep_ctl_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_ctl_r <= '0;
    end else begin
      prep_ctl_r <= prep_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prep_vec_r <= prep_vec_nxt;
  end

  // ---------------------------------------------------------------------------
  // Rotation chain
  // ---------------------------------------------------------------------------
  assign cor_ctl[0] = prep_ctl_r;
  assign cor_vec[0] = prep_vec_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    csp_cordic_cell #(
      .STEP (g)
    ) u_cordic_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (cor_ctl[g]),
      .vec_in  (cor_vec[g]),
      .ctl_out (cor_ctl[g+1]),
      .vec_out (cor_vec[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Round stage: undo the fold, round Q30 to Q16 (half up), clamp
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cor_ctl[CORDIC_STEPS].flip) begin
      x_flip = -cor_vec[CORDIC_STEPS].x;
      y_flip = -cor_vec[CORDIC_STEPS].y;
    end else begin
      x_flip = cor_vec[CORDIC_STEPS].x;
      y_flip = cor_vec[CORDIC_STEPS].y;
    end
    x_sh    = (x_flip + ROUND_BIAS) >>> 14;
    y_sh    = (y_flip + ROUND_BIAS) >>> 14;
    cos_nxt = clamp_q16(x_sh);
    sin_nxt = clamp_q16(y_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_valid_r <= 1'b0;
    end else begin
      rnd_valid_r <= cor_ctl[CORDIC_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  // ---------------------------------------------------------------------------
  // Scale stage: radius times cosine and sine
  // ---------------------------------------------------------------------------
  assign prod_x_nxt = signed'({1'b0, table_radius_r}) * cos_r;
  assign prod_y_nxt = signed'({1'b0, table_radius_r}) * sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= rnd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
  end

  // ---------------------------------------------------------------------------
  // Offset stage: screen y grows downward, so subtract the sine term
  // ---------------------------------------------------------------------------
  assign sum_x       = CENTER_X + SUM_W'(prod_x_r);
  assign sum_y       = CENTER_Y - SUM_W'(prod_y_r);
  assign pixel_x_nxt = to_pixel(sum_x);
  assign pixel_y_nxt = to_pixel(sum_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    pixel_x_r <= pixel_x_nxt;
    pixel_y_r <= pixel_y_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = pixel_x_r;
  assign out_pixel_y = pixel_y_r;

endmodule

FILE: hw/rtl/csp_checker.sv
module csp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import csp_pkg::*;

  // Reset flushes every transaction in flight
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Once out of reset the block takes a transaction in every cycle
  a_always_ready: assert property (@(posedge clk) rst_n && $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  // Every accepted transaction yields its result after the fixed latency
  a_result_arrives: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result");

  // No result without a transaction accepted at the right time
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without matching transaction");

endmodule

bind circle_seat_position csp_checker u_csp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
